// ===== rtl/byte_stream_ring_buffer_defines.svh =====
// Assertion macros used by the checker file of the ring buffer.
`ifndef BYTE_STREAM_RING_BUFFER_DEFINES_SVH
`define BYTE_STREAM_RING_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define BSRB_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ring buffer port assertion failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define BSRB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ring buffer port assertion failed");

`endif

// ===== rtl/bsrb_pkg.sv =====
// Package: payload types, codes and sizes of the byte stream ring buffer.
package bsrb_pkg;

   localparam int BUFFER_DEPTH = 1024;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int LEN_W        = 11;
   localparam int MAX_TAKE     = 64;
   localparam int GRANT_W      = 7;

   // command queue between front and back (power of two)
   localparam int CQ_DEPTH = 2;
   localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

   // response queue (power of two)
   localparam int RQ_DEPTH = 4;
   localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
   localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

   localparam logic [1:0] OP_GIVE  = 2'd0;
   localparam logic [1:0] OP_PUSH  = 2'd1;
   localparam logic [1:0] OP_TAKE  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_ROOM  = 2'd1;
   localparam logic [1:0] STAT_TOO_BIG  = 2'd2;
   localparam logic [1:0] STAT_EMPTY    = 2'd3;

   typedef struct packed {
      logic [1:0]       operation;
      logic [LEN_W-1:0] length;
      logic             first_of_chunk;
      logic [7:0]       data_in;
   } req_type;

   typedef struct packed {
      logic [7:0]         data_out;
      logic [1:0]         status;
      logic               last;
      logic [GRANT_W-1:0] granted;
      logic [LEN_W-1:0]   fill_count;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_GIVE,
      CMD_PUSH,
      CMD_CONT,
      CMD_TAKE,
      CMD_CLEAR,
      CMD_NULL_CHUNK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [LEN_W-1:0] length;
      logic [7:0]       data;
   } cmd_type;

endpackage

// ===== rtl/bsrb_front.sv =====
// Front end: accepts request transactions, classifies them, queues commands.
module bsrb_front import bsrb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type               entry_ff [CQ_DEPTH];
   logic [CQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CQ_CNT_W-1:0]   count_ff, count_in;
   cmd_type               new_cmd;
   logic                  accept;
   logic                  take_out;

   always_comb begin
      new_cmd.length = req_data.length;
      new_cmd.data   = req_data.data_in;
      case (req_data.operation)
         OP_CLEAR: new_cmd.kind = CMD_CLEAR;
         OP_TAKE:  new_cmd.kind = CMD_TAKE;
         OP_GIVE, OP_PUSH: begin
            if (!req_data.first_of_chunk) begin
               new_cmd.kind = CMD_CONT;
            end else if (req_data.length == '0) begin
               new_cmd.kind = CMD_NULL_CHUNK;
            end else if (req_data.operation == OP_GIVE) begin
               new_cmd.kind = CMD_GIVE;
            end else begin
               new_cmd.kind = CMD_PUSH;
            end
         end
         default: new_cmd.kind = CMD_CONT;
      endcase
   end

   assign req_full  = (count_ff == CQ_CNT_W'(CQ_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign accept    = req_push && !req_full;
   assign take_out  = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = accept   ? wr_ptr_ff + CQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = take_out ? rd_ptr_ff + CQ_PTR_W'(1) : rd_ptr_ff;
      case ({accept, take_out})
         2'b10:   count_in = count_ff + CQ_CNT_W'(1);
         2'b01:   count_in = count_ff - CQ_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== rtl/bsrb_back.sv =====
// Back end: ring state, byte store and command execution.
module bsrb_back import bsrb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [LEN_W-1:0]    csr_wdata,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_pop,
   input  logic [RQ_CNT_W-1:0] rq_count,
   output logic                res_we,
   output rsp_type             res
);

   typedef enum logic [1:0] {
      S_RUN  = 2'b01,
      S_TAKE = 2'b10
   } state_type;

   logic [7:0]         mem [BUFFER_DEPTH];
   logic [7:0]         mem_q_ff;

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   lim_ff, lim_in;
   logic [ADDR_W-1:0]  rp_ff, rp_in;
   logic [ADDR_W-1:0]  wp_ff, wp_in;
   logic [LEN_W-1:0]   stored_ff, stored_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic               accepted_ff, accepted_in;
   logic [ADDR_W-1:0]  scan_ff, scan_in;
   logic [GRANT_W-1:0] left_ff, left_in;
   logic [GRANT_W-1:0] grant_ff, grant_in;
   logic               pend_ff, pend_in;
   logic               pend_last_ff, pend_last_in;

   logic               mem_we;
   logic               rd_en;
   logic               imm_valid;
   rsp_type            imm;
   logic               room_one;
   logic               room_read;
   logic [RQ_CNT_W:0]  occ;
   logic [LEN_W:0]     sum_len;
   logic [LEN_W-1:0]   wp_sum;
   logic [ADDR_W-1:0]  rp_push;
   logic [LEN_W-1:0]   n_min;
   logic [GRANT_W-1:0] n_take;
   logic [LEN_W-1:0]   rp_sum;
   logic [ADDR_W-1:0]  rp_take;
   logic [LEN_W-1:0]   cap_eff;

   // advance a pointer by one inside the active ring size
   function automatic logic [ADDR_W-1:0] step1(input logic [ADDR_W-1:0] p,
                                               input logic [LEN_W-1:0] lim);
      logic [LEN_W-1:0] s;
      s = LEN_W'(p) + LEN_W'(1);
      return (s >= lim) ? '0 : s[ADDR_W-1:0];
   endfunction

   always_comb begin
      occ       = (RQ_CNT_W+1)'(rq_count) + (RQ_CNT_W+1)'(pend_ff);
      room_one  = (rq_count < RQ_CNT_W'(RQ_DEPTH));
      room_read = (occ < (RQ_CNT_W+1)'(RQ_DEPTH));

      sum_len = (LEN_W+1)'(stored_ff) + (LEN_W+1)'(cmd.length);

      // push drops just enough old bytes: new read pointer is wp + len, less lim if that reaches lim
      wp_sum  = LEN_W'(wp_ff) + cmd.length;
      rp_push = (wp_sum >= lim_ff) ? ADDR_W'(wp_sum - lim_ff) : ADDR_W'(wp_sum);

      n_min  = (cmd.length < stored_ff) ? cmd.length : stored_ff;
      n_take = (n_min > LEN_W'(MAX_TAKE)) ? GRANT_W'(MAX_TAKE) : GRANT_W'(n_min);
      rp_sum  = LEN_W'(rp_ff) + LEN_W'(n_take);
      rp_take = (rp_sum >= lim_ff) ? ADDR_W'(rp_sum - lim_ff) : ADDR_W'(rp_sum);

      if (csr_wdata == '0) begin
         cap_eff = LEN_W'(1);
      end else if (csr_wdata > LEN_W'(BUFFER_DEPTH)) begin
         cap_eff = LEN_W'(BUFFER_DEPTH);
      end else begin
         cap_eff = csr_wdata;
      end
   end

   always_comb begin
      state_in     = state_ff;
      lim_in       = lim_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      stored_in    = stored_ff;
      remain_in    = remain_ff;
      accepted_in  = accepted_ff;
      scan_in      = scan_ff;
      left_in      = left_ff;
      grant_in     = grant_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      cmd_pop      = 1'b0;
      imm_valid    = 1'b0;
      imm.data_out = '0;
      imm.status   = STAT_OK;
      imm.last     = 1'b1;
      imm.granted  = '0;

      case (state_ff)
         S_RUN: begin
            if (cmd_valid && !pend_ff && room_one) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_CLEAR: begin
                     rp_in       = '0;
                     wp_in       = '0;
                     stored_in   = '0;
                     remain_in   = '0;
                     accepted_in = 1'b0;
                     imm_valid   = 1'b1;
                  end
                  CMD_NULL_CHUNK: begin
                     remain_in   = '0;
                     accepted_in = 1'b0;
                     imm_valid   = 1'b1;
                  end
                  CMD_GIVE: begin
                     remain_in = cmd.length - LEN_W'(1);
                     imm_valid = 1'b1;
                     if (sum_len <= (LEN_W+1)'(lim_ff)) begin
                        accepted_in = 1'b1;
                        mem_we      = 1'b1;
                        wp_in       = step1(wp_ff, lim_ff);
                        stored_in   = stored_ff + LEN_W'(1);
                     end else begin
                        accepted_in = 1'b0;
                        imm.status  = (cmd.length <= lim_ff) ? STAT_NO_ROOM : STAT_TOO_BIG;
                     end
                  end
                  CMD_PUSH: begin
                     remain_in = cmd.length - LEN_W'(1);
                     imm_valid = 1'b1;
                     if (cmd.length > lim_ff) begin
                        accepted_in = 1'b0;
                        imm.status  = STAT_TOO_BIG;
                     end else begin
                        accepted_in = 1'b1;
                        mem_we      = 1'b1;
                        wp_in       = step1(wp_ff, lim_ff);
                        if (sum_len > (LEN_W+1)'(lim_ff)) begin
                           rp_in     = rp_push;
                           stored_in = lim_ff - cmd.length + LEN_W'(1);
                        end else begin
                           stored_in = stored_ff + LEN_W'(1);
                        end
                     end
                  end
                  CMD_CONT: begin
                     if (remain_ff != '0) begin
                        remain_in = remain_ff - LEN_W'(1);
                        if (accepted_ff) begin
                           mem_we = 1'b1;
                           wp_in  = step1(wp_ff, lim_ff);
                           // ring full: overwrite the oldest byte
                           if (stored_ff >= lim_ff) begin
                              rp_in = step1(rp_ff, lim_ff);
                           end else begin
                              stored_in = stored_ff + LEN_W'(1);
                           end
                        end
                     end
                  end
                  CMD_TAKE: begin
                     if (stored_ff == '0) begin
                        imm_valid  = 1'b1;
                        imm.status = STAT_EMPTY;
                     end else if (n_take == '0) begin
                        imm_valid = 1'b1;
                     end else begin
                        stored_in = stored_ff - LEN_W'(n_take);
                        rp_in     = rp_take;
                        scan_in   = rp_ff;
                        left_in   = n_take;
                        grant_in  = n_take;
                        state_in  = S_TAKE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TAKE: begin
            if (room_read) begin
               rd_en        = 1'b1;
               scan_in      = step1(scan_ff, lim_ff);
               left_in      = left_ff - GRANT_W'(1);
               pend_in      = 1'b1;
               pend_last_in = (left_ff == GRANT_W'(1));
               if (left_ff == GRANT_W'(1)) begin
                  state_in = S_RUN;
               end
            end
         end
         default: state_in = S_RUN;
      endcase

      imm.fill_count = stored_in;

      // a capacity write empties the ring and closes any open chunk
      if (csr_we) begin
         lim_in      = cap_eff;
         rp_in       = '0;
         wp_in       = '0;
         stored_in   = '0;
         remain_in   = '0;
         accepted_in = 1'b0;
         state_in    = S_RUN;
      end
   end

   always_comb begin
      res_we = imm_valid || pend_ff;
      if (pend_ff) begin
         res.data_out   = mem_q_ff;
         res.status     = STAT_OK;
         res.last       = pend_last_ff;
         res.granted    = grant_ff;
         res.fill_count = stored_ff;
      end else begin
         res = imm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_RUN;
         lim_ff      <= LEN_W'(BUFFER_DEPTH);
         rp_ff       <= '0;
         wp_ff       <= '0;
         stored_ff   <= '0;
         remain_ff   <= '0;
         accepted_ff <= 1'b0;
         left_ff     <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         lim_ff      <= lim_in;
         rp_ff       <= rp_in;
         wp_ff       <= wp_in;
         stored_ff   <= stored_in;
         remain_ff   <= remain_in;
         accepted_ff <= accepted_in;
         left_ff     <= left_in;
         pend_ff     <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      grant_ff     <= grant_in;
      pend_last_ff <= pend_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= cmd.data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[scan_ff];
      end
   end

endmodule

// ===== rtl/bsrb_rsp_queue.sv =====
// Response queue: holds result transactions until the consumer pops them.
module bsrb_rsp_queue import bsrb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  rsp_type             wr_data,
   output logic [RQ_CNT_W-1:0] count,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rsp_type             rsp_data
);

   rsp_type             entry_ff [RQ_DEPTH];
   logic [RQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RQ_CNT_W-1:0] count_ff, count_in;
   logic                take_out;

   assign count     = count_ff;
   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign take_out  = rsp_pop && !rsp_empty;

   // the back end only writes when it has seen room
   always_comb begin
      wr_ptr_in = wr_en    ? wr_ptr_ff + RQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = take_out ? rd_ptr_ff + RQ_PTR_W'(1) : rd_ptr_ff;
      case ({wr_en, take_out})
         2'b10:   count_in = count_ff + RQ_CNT_W'(1);
         2'b01:   count_in = count_ff - RQ_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/byte_stream_ring_buffer.sv =====
// Top level of the byte stream ring buffer.
//
//   channel   direction  handshake               payload
//   req_      in         req_push / req_full     req_data  (req_type)
//   rsp_      out        rsp_pop / rsp_empty     rsp_data  (rsp_type)
//   csr_      in         csr_we                  csr_wdata (capacity)
//
// Chunk bytes, clears, zero-length chunks and one-result takes are each
// handled in a single back end step; a take of n bytes has a start step, a
// read of each byte from the registered store read port, and a step to write the last byte.
// Reset is synchronous; the byte store is not cleared, so there is no sweep.
// A full response queue stalls the back end; a full command queue raises
// req_full, while already queued commands keep running.
module byte_stream_ring_buffer import bsrb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  req_type          req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [LEN_W-1:0] csr_wdata
);

   logic                cmd_valid;
   cmd_type             cmd;
   logic                cmd_pop;
   logic [RQ_CNT_W-1:0] rq_count;
   logic                res_we;
   rsp_type             res;

   bsrb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   bsrb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rq_count  (rq_count),
      .res_we    (res_we),
      .res       (res)
   );

   bsrb_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (res_we),
      .wr_data   (res),
      .count     (rq_count),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/bsrb_checker.sv =====
// Port-level checker for the byte stream ring buffer, with its bind.
`include "byte_stream_ring_buffer_defines.svh"

module bsrb_checker import bsrb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // both queues come out of reset empty
   `BSRB_ASSERT_IMPL(a_out_of_reset, $past(reset), rsp_empty && !req_full)

   // a waiting result holds until it is popped
   `BSRB_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))

   // bytes of one take share grant and fill count
   `BSRB_ASSERT_NEXT(a_take_burst, !rsp_empty && rsp_pop && !rsp_data.last, rsp_empty || (rsp_data.granted == $past(rsp_data.granted) && rsp_data.fill_count == $past(rsp_data.fill_count)))

endmodule

bind byte_stream_ring_buffer bsrb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
